[src/cvt_pkg.sv]
`timescale 1ns / 1ps

package cvt_pkg;

    // Field widths of the request and result beats.
    localparam int REQ_BITS    = 3;
    localparam int ITEM_BITS   = 16;
    localparam int POS_BITS    = 4;
    localparam int STATUS_BITS = 3;
    localparam int DIST_BITS   = 5;
    localparam int TOTAL_BITS  = 36;

    typedef logic [REQ_BITS-1:0]    t_req;
    typedef logic [ITEM_BITS-1:0]   t_item;
    typedef logic [POS_BITS-1:0]    t_pos;
    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [DIST_BITS-1:0]   t_dist;
    typedef logic [TOTAL_BITS-1:0]  t_total;

    // Request codes.
    localparam t_req REQ_ADD    = 3'd0;
    localparam t_req REQ_REMOVE = 3'd1;
    localparam t_req REQ_QUERY  = 3'd2;
    localparam t_req REQ_SET    = 3'd3;
    localparam t_req REQ_TOTAL  = 3'd4;
    localparam t_req REQ_READ   = 3'd5;

    // Result status codes.
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_NOT_FOUND = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_SAT       = 3'd3;
    localparam t_status ST_BAD_POS   = 3'd4;

    localparam t_total TOTAL_MAX = '1;

    // What a table sweep does with each entry it reads.
    typedef enum logic [1:0] {
        SWP_LOCATE,
        SWP_SUM,
        SWP_SHIFT
    } t_sweep_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load;
        logic        sweep;
        t_sweep_mode mode;
        logic        shift_start;
        logic        pos_read;
        logic        apply;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_done;
        logic hit;
        logic is_remove;
    } t_stat;

endpackage

[src/cvt_ctrl.sv]
`timescale 1ns / 1ps

module cvt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  cvt_pkg::t_req  i_req_type,
    input  cvt_pkg::t_stat i_stat,
    output cvt_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOCATE,
        S_SHIFT,
        S_SUM,
        S_POSRD,
        S_APPLY
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_valid;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mode = cvt_pkg::SWP_LOCATE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_type) inside
                        cvt_pkg::REQ_ADD, cvt_pkg::REQ_REMOVE,
                        cvt_pkg::REQ_QUERY, cvt_pkg::REQ_SET: n_state = S_LOCATE;
                        cvt_pkg::REQ_TOTAL: n_state = S_SUM;
                        cvt_pkg::REQ_READ:  n_state = S_POSRD;
                        default:            n_state = S_APPLY;
                    endcase
                end
            end
            S_LOCATE: begin
                o_cmd.sweep = 1'b1;
                o_cmd.mode  = cvt_pkg::SWP_LOCATE;
                if (i_stat.sweep_done) begin
                    if (i_stat.is_remove && i_stat.hit) begin
                        o_cmd.shift_start = 1'b1;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.sweep = 1'b1;
                o_cmd.mode  = cvt_pkg::SWP_SHIFT;
                if (i_stat.sweep_done) begin
                    n_state = S_APPLY;
                end
            end
            S_SUM: begin
                o_cmd.sweep = 1'b1;
                o_cmd.mode  = cvt_pkg::SWP_SUM;
                if (i_stat.sweep_done) begin
                    n_state = S_APPLY;
                end
            end
            S_POSRD: begin
                o_cmd.pos_read = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_APPLY);
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_state == S_APPLY) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule

[src/cvt_datapath.sv]
`timescale 1ns / 1ps

module cvt_datapath #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_BITS  = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cvt_pkg::t_cmd    i_cmd,
    input  cvt_pkg::t_req    i_req_type,
    input  cvt_pkg::t_item   i_item_value,
    input  cvt_pkg::t_item   i_new_count,
    input  cvt_pkg::t_pos    i_position,
    output cvt_pkg::t_stat   o_stat,
    output cvt_pkg::t_status o_status,
    output logic             o_found,
    output cvt_pkg::t_item   o_count_out,
    output cvt_pkg::t_item   o_entry_value,
    output cvt_pkg::t_total  o_total_out,
    output cvt_pkg::t_dist   o_distinct_out
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int PCW = (CW > cvt_pkg::POS_BITS) ? CW : cvt_pkg::POS_BITS;
    localparam int NW  = (COUNT_BITS > cvt_pkg::ITEM_BITS) ? COUNT_BITS : cvt_pkg::ITEM_BITS;
    localparam int PRW = VALUE_BITS + COUNT_BITS;
    localparam int TB  = cvt_pkg::TOTAL_BITS;
    localparam int SW  = ((PRW > TB) ? PRW : TB) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [VALUE_BITS-1:0] r_value_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] r_count_mem [TABLE_DEPTH];

    cvt_pkg::t_req         r_req;
    logic [VALUE_BITS-1:0] r_val;
    cvt_pkg::t_item        r_nc;
    cvt_pkg::t_pos         r_pos;
    logic [CW-1:0]         r_dist, n_dist;
    logic [CW-1:0]         r_addr;
    logic                  r_dv, r_pv, r_hit;
    logic [AW-1:0]         r_rd_idx, r_hit_idx;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [COUNT_BITS-1:0] r_rd_cnt, r_hit_cnt;
    logic [PRW-1:0]        r_prod;
    cvt_pkg::t_total       r_total;
    logic [SW-1:0]         acc_sum;

    cvt_pkg::t_status      r_o_status, a_status;
    logic                  r_o_found;
    cvt_pkg::t_item        r_o_cnt, a_cnt, r_o_ev, a_ev;
    cvt_pkg::t_total       r_o_total, a_total;
    cvt_pkg::t_dist        r_o_dist;

    logic                  can_issue, issue, rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wv_en, wc_en;
    logic [AW-1:0]         w_addr;
    logic [VALUE_BITS-1:0] w_val;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [PCW-1:0]        pos_ext;
    logic                  pos_ok, nc_over;

    // A sweep reads one entry a cycle; a locate stops reading once it has a hit.
    assign can_issue = (r_addr < r_dist) &&
                       !((i_cmd.mode == cvt_pkg::SWP_LOCATE) && r_hit);
    assign issue     = i_cmd.sweep && can_issue;
    assign pos_ext   = PCW'(r_pos);
    assign pos_ok    = pos_ext < PCW'(r_dist);
    assign rd_en     = issue || i_cmd.pos_read;
    assign rd_addr   = i_cmd.pos_read ? pos_ext[AW-1:0] : r_addr[AW-1:0];
    assign nc_over   = NW'(r_nc) > NW'(COUNT_MAX);
    assign acc_sum   = SW'(r_prod) + SW'(r_total);

    assign o_stat.sweep_done = !can_issue && !r_dv && !r_pv;
    assign o_stat.hit        = r_hit;
    assign o_stat.is_remove  = (r_req == cvt_pkg::REQ_REMOVE);

    always_comb begin
        a_status = cvt_pkg::ST_OK;
        a_cnt    = '0;
        a_ev     = '0;
        a_total  = '0;
        n_dist   = r_dist;
        wv_en    = 1'b0;
        wc_en    = 1'b0;
        w_addr   = r_hit_idx;
        w_val    = r_val;
        w_cnt    = r_hit_cnt;
        if (i_cmd.sweep && (i_cmd.mode == cvt_pkg::SWP_SHIFT) && r_dv) begin
            wv_en  = 1'b1;
            wc_en  = 1'b1;
            w_addr = r_rd_idx - AW'(1);
            w_val  = r_rd_val;
            w_cnt  = r_rd_cnt;
        end
        if (i_cmd.apply) begin
            unique case (r_req)
                cvt_pkg::REQ_ADD: begin
                    if (r_hit) begin
                        if (r_hit_cnt == COUNT_MAX) begin
                            a_status = cvt_pkg::ST_SAT;
                        end else begin
                            wc_en = 1'b1;
                            w_cnt = r_hit_cnt + COUNT_BITS'(1);
                        end
                    end else if (r_dist >= CW'(TABLE_DEPTH)) begin
                        a_status = cvt_pkg::ST_FULL;
                    end else begin
                        wv_en  = 1'b1;
                        wc_en  = 1'b1;
                        w_addr = r_dist[AW-1:0];
                        w_val  = r_val;
                        w_cnt  = COUNT_BITS'(1);
                        n_dist = r_dist + CW'(1);
                    end
                end
                cvt_pkg::REQ_REMOVE: begin
                    if (r_hit) begin
                        n_dist = r_dist - CW'(1);
                    end else begin
                        a_status = cvt_pkg::ST_NOT_FOUND;
                    end
                end
                cvt_pkg::REQ_QUERY: begin
                    if (r_hit) begin
                        a_cnt = cvt_pkg::t_item'(r_hit_cnt);
                    end else begin
                        a_status = cvt_pkg::ST_NOT_FOUND;
                    end
                end
                cvt_pkg::REQ_SET: begin
                    if (r_hit) begin
                        wc_en = 1'b1;
                        if (nc_over) begin
                            w_cnt    = COUNT_MAX;
                            a_status = cvt_pkg::ST_SAT;
                        end else begin
                            w_cnt = COUNT_BITS'(r_nc);
                        end
                    end else begin
                        a_status = cvt_pkg::ST_NOT_FOUND;
                    end
                end
                cvt_pkg::REQ_TOTAL: begin
                    a_total = r_total;
                end
                cvt_pkg::REQ_READ: begin
                    if (pos_ok) begin
                        a_ev  = cvt_pkg::t_item'(r_rd_val);
                        a_cnt = cvt_pkg::t_item'(r_rd_cnt);
                    end else begin
                        a_status = cvt_pkg::ST_BAD_POS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Table storage: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (wv_en) begin
            r_value_mem[w_addr] <= w_val;
        end
        if (wc_en) begin
            r_count_mem[w_addr] <= w_cnt;
        end
        if (rd_en) begin
            r_rd_val <= r_value_mem[rd_addr];
            r_rd_cnt <= r_count_mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_prod <= PRW'(r_rd_val) * PRW'(r_rd_cnt);
        if (issue) begin
            r_rd_idx <= r_addr[AW-1:0];
        end
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_val <= VALUE_BITS'(i_item_value);
            r_nc  <= i_new_count;
            r_pos <= i_position;
        end
        if (i_cmd.sweep && (i_cmd.mode == cvt_pkg::SWP_LOCATE) && r_dv && !r_hit &&
            (r_rd_val == r_val)) begin
            r_hit_idx <= r_rd_idx;
            r_hit_cnt <= r_rd_cnt;
        end
        if (i_cmd.apply) begin
            r_o_status <= a_status;
            r_o_found  <= r_hit;
            r_o_cnt    <= a_cnt;
            r_o_ev     <= a_ev;
            r_o_total  <= a_total;
            r_o_dist   <= cvt_pkg::t_dist'(n_dist);
        end
    end

    // Control registers. No read is issued while a request is loaded or a
    // shift is started, so the read and product valid flags fall by themselves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist  <= '0;
            r_addr  <= '0;
            r_dv    <= 1'b0;
            r_pv    <= 1'b0;
            r_hit   <= 1'b0;
            r_total <= '0;
        end else begin
            r_dist <= n_dist;
            r_dv   <= issue;
            r_pv   <= r_dv && i_cmd.sweep && (i_cmd.mode == cvt_pkg::SWP_SUM);
            if (issue) begin
                r_addr <= r_addr + CW'(1);
            end
            if (i_cmd.sweep && (i_cmd.mode == cvt_pkg::SWP_LOCATE) && r_dv && !r_hit &&
                (r_rd_val == r_val)) begin
                r_hit <= 1'b1;
            end
            if (r_pv) begin
                r_total <= (acc_sum > SW'(cvt_pkg::TOTAL_MAX)) ? cvt_pkg::TOTAL_MAX
                                                              : acc_sum[TB-1:0];
            end
            if (i_cmd.shift_start) begin
                r_addr <= CW'(r_hit_idx) + CW'(1);
            end
            if (i_cmd.load) begin
                r_addr  <= '0;
                r_hit   <= 1'b0;
                r_total <= '0;
            end
        end
    end

    assign o_status       = r_o_status;
    assign o_found        = r_o_found;
    assign o_count_out    = r_o_cnt;
    assign o_entry_value  = r_o_ev;
    assign o_total_out    = r_o_total;
    assign o_distinct_out = r_o_dist;

endmodule

[src/counted_value_table.sv]
`timescale 1ns / 1ps

// Counted value table: a bag of distinct values, each with an occurrence count,
// kept packed at positions below the distinct count in order of first insertion.
// A request beat is taken at a rising edge where start is high and busy is low;
// busy then stays high until the request has finished. The result beat appears
// on the o_ result ports for exactly one cycle, marked by o_valid, and the
// receiver has no way to hold it off. A new request may be given in that cycle.
// Each request runs its steps in order: add, query, set_count and remove search
// the table up to a hit or its end, and a remove that hits then shifts the
// later entries down; total sums all entries, read_entry reads its one
// position and an unused code goes straight to the result. The search, the sum
// and the shift all sweep the single read port of the table memory one entry a
// cycle. Reset empties the table at once: the distinct count is cleared and no
// entry at or above it is ever used, so no clearing pass runs.

module counted_value_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_BITS  = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cvt_pkg::t_req    i_req_type,
    input  cvt_pkg::t_item   i_item_value,
    input  cvt_pkg::t_item   i_new_count,
    input  cvt_pkg::t_pos    i_position,
    output logic             o_valid,
    output cvt_pkg::t_status o_status,
    output logic             o_found,
    output cvt_pkg::t_item   o_count_out,
    output cvt_pkg::t_item   o_entry_value,
    output cvt_pkg::t_total  o_total_out,
    output cvt_pkg::t_dist   o_distinct_out
);

    cvt_pkg::t_cmd  cmd;
    cvt_pkg::t_stat stat;

    // The controller sequences each request through search, shift or sum sweeps or a position read.
    cvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_valid    (o_valid)
    );

    // The datapath holds the table memory, the distinct count and the result registers.
    cvt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_item_value   (i_item_value),
        .i_new_count    (i_new_count),
        .i_position     (i_position),
        .o_stat         (stat),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_count_out    (o_count_out),
        .o_entry_value  (o_entry_value),
        .o_total_out    (o_total_out),
        .o_distinct_out (o_distinct_out)
    );

endmodule

[test/bag_tracker_pkg.sv]
`timescale 1ns / 1ps

package bag_tracker_pkg;

    import cvt_pkg::*;

    localparam int    TRACK_DEPTH = 16;
    localparam t_item COUNT_MAX   = '1;

    // One result beat, field by field.
    typedef struct {
        t_status status;
        logic    found;
        t_item   count;
        t_item   entry;
        t_total  total;
        t_dist   distinct;
    } bag_result_t;

    // Keeps a shadow copy of the bag, works out the result of every accepted
    // request and checks the result beats against it in order.
    class bag_tracker;

        t_item       held_value [TRACK_DEPTH];
        t_item       held_count [TRACK_DEPTH];
        int unsigned distinct;
        bag_result_t pending_results [$];
        int unsigned error_count;

        function new();
            distinct    = 0;
            error_count = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        function int outstanding();
            return pending_results.size();
        endfunction

        function void note_request(t_req req, t_item value, t_item new_count,
                                   t_pos position);
            bag_result_t         want;
            int unsigned         slot;
            int unsigned         i;
            logic                present;
            logic [TOTAL_BITS:0] sum;

            want.status = ST_OK;
            want.found  = 1'b0;
            want.count  = '0;
            want.entry  = '0;
            want.total  = '0;
            slot        = distinct;
            present     = 1'b0;
            sum         = '0;

            // Only the value-keyed requests search the table.
            if (req <= REQ_SET) begin
                for (i = 0; i < distinct && !present; i++) begin
                    if (held_value[i] == value) begin
                        slot    = i;
                        present = 1'b1;
                    end
                end
            end

            case (req)
                REQ_ADD: begin
                    if (present) begin
                        if (held_count[slot] == COUNT_MAX)
                            want.status = ST_SAT;
                        else
                            held_count[slot] = held_count[slot] + 1'b1;
                    end else if (distinct >= TRACK_DEPTH) begin
                        want.status = ST_FULL;
                    end else begin
                        held_value[distinct] = value;
                        held_count[distinct] = t_item'(1);
                        distinct++;
                    end
                end
                REQ_REMOVE: begin
                    if (present) begin
                        for (i = slot; i + 1 < distinct; i++) begin
                            held_value[i] = held_value[i + 1];
                            held_count[i] = held_count[i + 1];
                        end
                        distinct--;
                    end else begin
                        want.status = ST_NOT_FOUND;
                    end
                end
                REQ_QUERY: begin
                    if (present)
                        want.count = held_count[slot];
                    else
                        want.status = ST_NOT_FOUND;
                end
                REQ_SET: begin
                    // The count field is as wide as a stored count, so it can
                    // never exceed the maximum and is stored as given.
                    if (present)
                        held_count[slot] = new_count;
                    else
                        want.status = ST_NOT_FOUND;
                end
                REQ_TOTAL: begin
                    for (i = 0; i < distinct; i++) begin
                        sum = sum + held_value[i] * held_count[i];
                        if (sum > {1'b0, TOTAL_MAX})
                            sum = {1'b0, TOTAL_MAX};
                    end
                    want.total = sum[TOTAL_BITS-1:0];
                end
                REQ_READ: begin
                    if (position < distinct) begin
                        want.entry = held_value[position];
                        want.count = held_count[position];
                    end else begin
                        want.status = ST_BAD_POS;
                    end
                end
                default: begin
                end
            endcase

            want.found    = present;
            want.distinct = t_dist'(distinct);
            pending_results.insert(pending_results.size(), want);
        endfunction

        task check_result(bag_result_t got);
            bag_result_t want;

            if (pending_results.size() == 0) begin
                report("result beat with no request outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.found !== want.found)
                report($sformatf("found %0b, wanted %0b", got.found, want.found));
            if (got.count !== want.count)
                report($sformatf("count_out %0h, wanted %0h", got.count, want.count));
            if (got.entry !== want.entry)
                report($sformatf("entry_value %0h, wanted %0h", got.entry, want.entry));
            if (got.total !== want.total)
                report($sformatf("total_out %0h, wanted %0h", got.total, want.total));
            if (got.distinct !== want.distinct)
                report($sformatf("distinct_out %0d, wanted %0d",
                                 got.distinct, want.distinct));
        endtask

    endclass

endpackage

[test/tb_counted_value_table.sv]
`timescale 1ns / 1ps

// Self-checking bench for the counted value table. Request beats are driven at
// the falling edge and counted as accepted at the rising edge where start is
// high and busy is low; result beats are sampled at the rising edge whenever
// o_valid is high. A shadow bag in the tracker class predicts every result.
module tb_counted_value_table;

    import cvt_pkg::*;
    import bag_tracker_pkg::*;

    // The two request codes that the block must treat as no-ops.
    localparam t_req REQ_SPARE_LO = 3'd6;
    localparam t_req REQ_SPARE_HI = 3'd7;

    // Requests and sender gaps are far shorter than this, so this many silent
    // cycles can only mean a hang.
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_BEATS  = 500;
    localparam int POOL_SIZE     = 24;
    localparam int TAIL_CYCLES   = 60;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_req    i_req_type;
    t_item   i_item_value;
    t_item   i_new_count;
    t_pos    i_position;
    logic    o_valid;
    t_status o_status;
    logic    o_found;
    t_item   o_count_out;
    t_item   o_entry_value;
    t_total  o_total_out;
    t_dist   o_distinct_out;

    bag_tracker  tracker;
    bag_result_t seen;
    int          stall_cycles;

    // Values are mostly drawn from a pool a little larger than the table, so
    // that hits are common and the table fills up now and then.
    t_item value_pool [POOL_SIZE];

    counted_value_table u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_item_value   (i_item_value),
        .i_new_count    (i_new_count),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_count_out    (o_count_out),
        .o_entry_value  (o_entry_value),
        .o_total_out    (o_total_out),
        .o_distinct_out (o_distinct_out)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Result monitor. The receiver cannot stall, so every cycle with o_valid
    // high is one result beat.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            seen.status   = o_status;
            seen.found    = o_found;
            seen.count    = o_count_out;
            seen.entry    = o_entry_value;
            seen.total    = o_total_out;
            seen.distinct = o_distinct_out;
            tracker.check_result(seen);
        end
    end

    // Counts the cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Presents one request beat and holds it until the block takes it.
    task automatic issue_request(t_req req, t_item value, t_item count, t_pos pos);
        @(negedge i_clk);
        start        = 1'b1;
        i_req_type   = req;
        i_item_value = value;
        i_new_count  = count;
        i_position   = pos;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        tracker.note_request(req, value, count, pos);
    endtask

    // Drops start for a random gap, about 23 times in a hundred. The gaps are
    // long enough to land anywhere within the work on the previous beat.
    task automatic maybe_idle(bit calm);
        int gap;

        if (!calm && $urandom_range(0, 99) < 23) begin
            gap = $urandom_range(1, 40);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1)
                @(negedge i_clk);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_item pick_value();
        if ($urandom_range(0, 99) < 12)
            return t_item'($urandom);
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Counts lean towards the edges so that saturation on add is reached.
    function automatic t_item pick_count();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 15)
            return COUNT_MAX;
        if (roll < 25)
            return COUNT_MAX - 1'b1;
        if (roll < 35)
            return '0;
        if (roll < 45)
            return t_item'($urandom_range(1, 5));
        return t_item'($urandom);
    endfunction

    // Request mix; the weight of removes sets how full the table tends to be.
    function automatic t_req pick_request(int remove_weight);
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < remove_weight)
            return REQ_REMOVE;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return REQ_ADD;
        if (roll < 57)
            return REQ_QUERY;
        if (roll < 70)
            return REQ_SET;
        if (roll < 80)
            return REQ_TOTAL;
        if (roll < 94)
            return REQ_READ;
        if (roll < 97)
            return REQ_SPARE_LO;
        return REQ_SPARE_HI;
    endfunction

    initial begin
        int k;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req_type   = REQ_ADD;
        i_item_value = '0;
        i_new_count  = '0;
        i_position   = '0;
        stall_cycles = 0;
        tracker      = new();

        value_pool[0] = '0;
        value_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
            value_pool[k] = t_item'($urandom);

        repeat (8)
            @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. On the empty table every lookup misses, a read is out
        // of range and the total is zero.
        issue_request(REQ_READ,   '0,       '0, 4'd0);
        issue_request(REQ_TOTAL,  '0,       '0, 4'd0);
        issue_request(REQ_QUERY,  16'h1234, '0, 4'd0);
        issue_request(REQ_REMOVE, 16'h1234, '0, 4'd0);
        issue_request(REQ_SET,    16'h1234, 16'd7, 4'd0);
        // Extreme values, a repeated add, and an add that meets the count
        // ceiling and has to saturate.
        issue_request(REQ_ADD,    '1, '0, 4'd0);
        issue_request(REQ_ADD,    '0, '0, 4'd0);
        issue_request(REQ_ADD,    '1, '0, 4'd0);
        issue_request(REQ_SET,    '1, COUNT_MAX, 4'd0);
        issue_request(REQ_ADD,    '1, '0, 4'd0);
        issue_request(REQ_QUERY,  '1, '0, 4'd0);
        issue_request(REQ_TOTAL,  '0, '0, 4'd0);
        // A count set to zero leaves its entry in place.
        issue_request(REQ_SET,    '0, '0, 4'd0);
        issue_request(REQ_QUERY,  '0, '0, 4'd0);
        issue_request(REQ_ADD,    16'hA5A5, '0, 4'd0);
        issue_request(REQ_READ,   '0, '0, 4'd2);
        issue_request(REQ_READ,   '0, '0, 4'd3);
        issue_request(REQ_READ,   '0, '0, 4'd15);
        // Removing the first entry shifts the others down.
        issue_request(REQ_REMOVE, '1, '0, 4'd0);
        issue_request(REQ_READ,   '0, '0, 4'd0);
        issue_request(REQ_READ,   '0, '0, 4'd1);
        issue_request(REQ_SPARE_LO, '1, '1, 4'd15);
        issue_request(REQ_SPARE_HI, '1, '1, 4'd15);
        issue_request(REQ_TOTAL,  '0, '0, 4'd0);

        // Random part. Removes are rare in the first half so the table fills
        // and adds are refused, then more common so it empties again. There
        // is a stretch with no gaps at all, and twice the sender waits until
        // every result is back.
        for (k = 0; k < RANDOM_BEATS; k++) begin
            if (k == 250 || k == 420)
                drain_results();
            maybe_idle(k >= 150 && k < 300);
            issue_request(pick_request(k < 250 ? 8 : 20), pick_value(), pick_count(),
                          t_pos'($urandom_range(0, 15)));
        end

        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge i_clk);
        if (tracker.error_count == 0 && tracker.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
src/cvt_pkg.sv
src/cvt_ctrl.sv
src/cvt_datapath.sv
src/counted_value_table.sv
test/bag_tracker_pkg.sv
test/tb_counted_value_table.sv
